### design/olids_pkg.sv
// Shared types and constants for the ordered list with insert, delete and search.
`timescale 1ns / 1ps

package olids_pkg;

	// List storage geometry
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = ADDR_W + 1;
	localparam int DATA_W   = 32;

	// Operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	// Status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_PUT,
		S_DEL,
		S_SRCH
	} olids_state_t;

	// Request payload
	typedef struct packed {
		logic [1:0]               operation;
		logic [CNT_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} olids_req_t;

	// Result payload
	typedef struct packed {
		logic [1:0]        status;
		logic              found;
		logic [ADDR_W-1:0] match_position;
		logic [CNT_W-1:0]  entry_count;
	} olids_rsp_t;

	// Storage port controls from the sequencer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} olids_ram_ctl_t;

endpackage

### design/olids_ram.sv
// List storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module olids_ram (
	input  logic                          clk,
	input  olids_pkg::olids_ram_ctl_t     ctl,
	output logic [olids_pkg::DATA_W-1:0]  rdata
);

	logic [olids_pkg::DATA_W-1:0] mem_q [olids_pkg::CAPACITY];

	// Write port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[ctl.waddr] <= ctl.wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem_q[ctl.raddr];
		end
	end

endmodule

### design/ordered_list_insert_delete_search.sv
// Top level: sequencer that walks the list storage for insert, delete and search.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values.
// A request (operation, position, value) is taken on a clock edge with start
// high and busy low. Exactly one result per request appears on rsp for one
// cycle, marked by done; the receiver has no way to hold it off.
// The sequencer moves one entry per cycle through the single storage read
// port (registered data) and write port, walking the list; done follows
// in the cycle after the last step:
//   insert: entries at position and above move up one place, then the value is written
//   delete: entries above position move down one place
//   search: entries are read from the first until one matches or the list ends
// Refused requests, unused codes and searches of an empty list need no walk:
// done follows in the cycle after the request and busy stays low.
// A result may sit on rsp while the next request is already taken.
// Reset empties the list (count 0); storage contents are left as they are
// and only entries below the count are ever read.
module ordered_list_insert_delete_search (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  olids_pkg::olids_req_t  req,
	output logic                   busy,
	output logic                   done,
	output olids_pkg::olids_rsp_t  rsp
);

	olids_pkg::olids_state_t           state_q, state_d;
	olids_pkg::olids_req_t             req_q;
	olids_pkg::olids_ram_ctl_t         ram_ctl;
	logic [olids_pkg::DATA_W-1:0]      rdata;
	logic [olids_pkg::CNT_W-1:0]       cnt_q;
	logic [olids_pkg::CNT_W-1:0]       left_q;
	logic [olids_pkg::ADDR_W-1:0]      ptr_q;
	logic [olids_pkg::ADDR_W-1:0]      paddr_q;
	logic                              pend_q;
	logic                              done_q;
	olids_pkg::olids_rsp_t             rsp_q;

	logic                              accept;
	logic                              ins_ok, del_ok, hit, issue;
	logic                              fin;
	olids_pkg::olids_rsp_t             fin_rsp;

	olids_ram u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.rdata (rdata)
	);

	// Request checks against the current count
	assign accept = start && (state_q == olids_pkg::S_IDLE);
	assign ins_ok = (cnt_q < olids_pkg::CNT_W'(olids_pkg::CAPACITY))
		&& (req.position <= cnt_q);
	assign del_ok = req.position < cnt_q;

	// Shared compare: data arriving from storage against the search value
	assign hit = (state_q == olids_pkg::S_SRCH) && pend_q
		&& (rdata == req_q.value);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			olids_pkg::S_IDLE: begin
				if (accept) begin
					unique case (req.operation)
						olids_pkg::OP_INSERT:
							state_d = ins_ok ? olids_pkg::S_INS : olids_pkg::S_IDLE;
						olids_pkg::OP_DELETE:
							state_d = del_ok ? olids_pkg::S_DEL : olids_pkg::S_IDLE;
						olids_pkg::OP_SEARCH:
							state_d = (cnt_q != '0) ? olids_pkg::S_SRCH
								: olids_pkg::S_IDLE;
						default:
							state_d = olids_pkg::S_IDLE;
					endcase
				end
			end
			olids_pkg::S_INS: begin
				if (left_q == '0) begin
					state_d = olids_pkg::S_INS_PUT;
				end
			end
			olids_pkg::S_INS_PUT: state_d = olids_pkg::S_IDLE;
			olids_pkg::S_DEL: begin
				if (left_q == '0) begin
					state_d = olids_pkg::S_IDLE;
				end
			end
			olids_pkg::S_SRCH: begin
				if (hit || ((left_q == '0) && !pend_q)) begin
					state_d = olids_pkg::S_IDLE;
				end
			end
			default: state_d = olids_pkg::S_IDLE;
		endcase
	end

	// Outputs: storage controls and completion
	always_comb begin
		ram_ctl       = '0;
		ram_ctl.raddr = ptr_q;
		issue         = 1'b0;
		fin           = 1'b0;
		fin_rsp       = '0;
		fin_rsp.entry_count = cnt_q;
		unique case (state_q)
			olids_pkg::S_IDLE: begin
				if (accept) begin
					fin = 1'b1;
					case (req.operation)
						olids_pkg::OP_INSERT: begin
							if (cnt_q >= olids_pkg::CNT_W'(olids_pkg::CAPACITY)) begin
								fin_rsp.status = olids_pkg::ST_FULL;
							end else if (!ins_ok) begin
								fin_rsp.status = olids_pkg::ST_BADPOS;
							end else begin
								fin = 1'b0;
							end
						end
						olids_pkg::OP_DELETE: begin
							if (!del_ok) begin
								fin_rsp.status = olids_pkg::ST_BADPOS;
							end else begin
								fin = 1'b0;
							end
						end
						olids_pkg::OP_SEARCH: fin = (cnt_q == '0);
						default: ;
					endcase
				end
			end
			olids_pkg::S_INS: begin
				// entry at paddr moves up one place
				issue         = (left_q != '0);
				ram_ctl.re    = issue;
				ram_ctl.we    = pend_q;
				ram_ctl.waddr = paddr_q + 1'b1;
				ram_ctl.wdata = rdata;
			end
			olids_pkg::S_INS_PUT: begin
				ram_ctl.we    = 1'b1;
				ram_ctl.waddr = req_q.position[olids_pkg::ADDR_W-1:0];
				ram_ctl.wdata = req_q.value;
				fin           = 1'b1;
				fin_rsp.entry_count = cnt_q + 1'b1;
			end
			olids_pkg::S_DEL: begin
				// entry at paddr moves down one place
				issue         = (left_q != '0);
				ram_ctl.re    = issue;
				ram_ctl.we    = pend_q;
				ram_ctl.waddr = paddr_q - 1'b1;
				ram_ctl.wdata = rdata;
				if (left_q == '0) begin
					fin = 1'b1;
					fin_rsp.entry_count = cnt_q - 1'b1;
				end
			end
			olids_pkg::S_SRCH: begin
				issue      = (left_q != '0) && !hit;
				ram_ctl.re = issue;
				if (hit) begin
					fin                    = 1'b1;
					fin_rsp.found          = 1'b1;
					fin_rsp.match_position = paddr_q;
				end else if ((left_q == '0) && !pend_q) begin
					fin = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olids_pkg::S_IDLE;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= issue;
			done_q  <= fin;
			if (fin) begin
				cnt_q <= fin_rsp.entry_count;
			end
		end
	end

	// Walk pointer, remaining reads, latched request and latched result
	always_ff @(posedge clk) begin
		paddr_q <= ptr_q;
		if (fin) begin
			rsp_q <= fin_rsp;
		end
		if (accept) begin
			req_q <= req;
			case (req.operation)
				olids_pkg::OP_INSERT: begin
					ptr_q  <= olids_pkg::ADDR_W'(cnt_q - 1'b1);
					left_q <= cnt_q - req.position;
				end
				olids_pkg::OP_DELETE: begin
					ptr_q  <= req.position[olids_pkg::ADDR_W-1:0] + 1'b1;
					left_q <= cnt_q - req.position - 1'b1;
				end
				default: begin
					ptr_q  <= '0;
					left_q <= cnt_q;
				end
			endcase
		end else if (issue) begin
			left_q <= left_q - 1'b1;
			ptr_q  <= (state_q == olids_pkg::S_INS) ? ptr_q - 1'b1 : ptr_q + 1'b1;
		end
	end

	assign busy = (state_q != olids_pkg::S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// Busy falling always comes with a result in the same cycle
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("walk ended without a result");

	// The count never exceeds the capacity
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= olids_pkg::CNT_W'(olids_pkg::CAPACITY))
		else $error("entry count above capacity");

	// The count only moves when a result is issued
	a_cnt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(cnt_q))
		else $error("count changed without a result");

	// A match is a completed request at a position inside the list
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.found) |->
			(rsp.status == olids_pkg::ST_DONE)
			&& ({1'b0, rsp.match_position} < rsp.entry_count))
		else $error("match outside the list");

endmodule

### sim/ordered_list_insert_delete_search_tb.sv
// Self-checking testbench for the ordered list: directed and random requests.
`timescale 1ns / 1ps

module ordered_list_insert_delete_search_tb;

	// Operation code the block does not use; it must leave the list alone
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_PRINTS  = 50;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start  = 1'b0;
	olids_pkg::olids_req_t req    = '0;
	logic                  busy;
	logic                  done;
	olids_pkg::olids_rsp_t rsp;

	// Predicted list contents and length
	logic signed [olids_pkg::DATA_W-1:0] list_mem [olids_pkg::CAPACITY];
	int                                  list_len = 0;

	olids_pkg::olids_rsp_t pending_results [$];
	int                    error_count = 0;
	int                    cycle_count = 0;
	int                    burst_left  = 0;

	ordered_list_insert_delete_search uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	// Apply one request to the predicted list and return the result it gives
	function automatic olids_pkg::olids_rsp_t list_apply(input olids_pkg::olids_req_t r);
		olids_pkg::olids_rsp_t o;
		int                    p;
		o = '0;
		p = int'(r.position);
		case (r.operation)
			olids_pkg::OP_INSERT: begin
				if (list_len >= olids_pkg::CAPACITY)
					o.status = olids_pkg::ST_FULL;
				else if (p > list_len)
					o.status = olids_pkg::ST_BADPOS;
				else begin
					for (int i = list_len; i > p; i--)
						list_mem[olids_pkg::ADDR_W'(i)] = list_mem[olids_pkg::ADDR_W'(i-1)];
					list_mem[olids_pkg::ADDR_W'(p)] = r.value;
					list_len++;
				end
			end
			olids_pkg::OP_DELETE: begin
				if (p >= list_len)
					o.status = olids_pkg::ST_BADPOS;
				else begin
					for (int i = p; i + 1 < list_len; i++)
						list_mem[olids_pkg::ADDR_W'(i)] = list_mem[olids_pkg::ADDR_W'(i+1)];
					list_len--;
				end
			end
			olids_pkg::OP_SEARCH: begin
				for (int i = 0; i < list_len && !o.found; i++) begin
					if (list_mem[olids_pkg::ADDR_W'(i)] == r.value) begin
						o.found          = 1'b1;
						o.match_position = olids_pkg::ADDR_W'(i);
					end
				end
			end
			default: ;
		endcase
		o.entry_count = olids_pkg::CNT_W'(list_len);
		return o;
	endfunction

	// Send one request in bursts with random gaps; predict on acceptance
	task automatic send_request(input logic [1:0] op,
			input logic [olids_pkg::CNT_W-1:0] pos,
			input logic signed [olids_pkg::DATA_W-1:0] val);
		olids_pkg::olids_req_t r;
		int                    gap;
		r.operation = op;
		r.position  = pos;
		r.value     = val;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req   <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(list_apply(r));
	endtask

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		olids_pkg::olids_rsp_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0)
				report_mismatch("result with no request outstanding");
			else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status exp %0d got %0d",
						want.status, rsp.status));
				if (rsp.found !== want.found)
					report_mismatch($sformatf("found exp %0d got %0d",
						want.found, rsp.found));
				if (rsp.match_position !== want.match_position)
					report_mismatch($sformatf("match_position exp %0d got %0d",
						want.match_position, rsp.match_position));
				if (rsp.entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count exp %0d got %0d",
						want.entry_count, rsp.entry_count));
			end
		end
	end

	// One random request; weights pick the operation mix
	task automatic random_item(input int ins_pct, input int del_pct, input bit noisy);
		int                                  roll;
		logic [1:0]                          op;
		logic [olids_pkg::CNT_W-1:0]         pos;
		logic signed [olids_pkg::DATA_W-1:0] val;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			op = olids_pkg::OP_INSERT;
		else if (roll < ins_pct + del_pct)
			op = olids_pkg::OP_DELETE;
		else
			op = olids_pkg::OP_SEARCH;
		if (noisy && $urandom_range(0, 9) == 0)
			op = OP_UNUSED;

		// Position: mostly legal, leaning to the ends of the list
		roll = $urandom_range(0, 3);
		if (noisy && $urandom_range(0, 2) == 0)
			pos = olids_pkg::CNT_W'($urandom_range(0, 127));
		else if (op == olids_pkg::OP_INSERT)
			pos = (roll == 0) ? '0 : (roll == 1) ? olids_pkg::CNT_W'(list_len) :
				olids_pkg::CNT_W'($urandom_range(0, list_len));
		else if (list_len == 0)
			pos = '0;
		else
			pos = (roll == 0) ? '0 : (roll == 1) ? olids_pkg::CNT_W'(list_len - 1) :
				olids_pkg::CNT_W'($urandom_range(0, list_len - 1));

		// Value: searches mostly hit, inserts often repeat small values
		roll = $urandom_range(0, 5);
		if (op == olids_pkg::OP_SEARCH && list_len > 0 && roll < 4)
			val = list_mem[olids_pkg::ADDR_W'($urandom_range(0, list_len - 1))];
		else if (roll < 2)
			val = $signed($urandom_range(0, 7)) - 4;
		else if (roll == 2)
			val = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
		else
			val = $urandom;
		send_request(op, pos, val);
	endtask

	// Refused and no-op requests while nothing is stored
	task automatic test_empty_list;
		send_request(olids_pkg::OP_DELETE, 0, 0);
		send_request(olids_pkg::OP_SEARCH, 0, 0);
		send_request(olids_pkg::OP_INSERT, 1, 5);
		send_request(OP_UNUSED, 127, -1);
		send_request(olids_pkg::OP_DELETE, 64, 32'sh80000000);
	endtask

	// Front, middle and end inserts and deletes with extreme values, plus searches
	task automatic test_edge_values;
		send_request(olids_pkg::OP_INSERT, 0, 32'sh7FFFFFFF);
		send_request(olids_pkg::OP_INSERT, 0, 32'sh80000000);
		send_request(olids_pkg::OP_INSERT, 2, 0);
		send_request(olids_pkg::OP_INSERT, 1, -1);
		send_request(olids_pkg::OP_INSERT, 5, 9);
		send_request(olids_pkg::OP_INSERT, 4, 32'sh7FFFFFFF);
		send_request(olids_pkg::OP_SEARCH, 0, 32'sh7FFFFFFF);
		send_request(olids_pkg::OP_SEARCH, 0, 32'sh80000000);
		send_request(olids_pkg::OP_SEARCH, 0, 12345);
		send_request(OP_UNUSED, 64, 7);
		send_request(olids_pkg::OP_DELETE, 0, 0);
		send_request(olids_pkg::OP_DELETE, 3, 0);
		send_request(olids_pkg::OP_DELETE, 1, 0);
		send_request(olids_pkg::OP_DELETE, 4, 0);
		send_request(olids_pkg::OP_SEARCH, 0, 0);
		send_request(olids_pkg::OP_DELETE, 1, 0);
		send_request(olids_pkg::OP_DELETE, 0, 0);
		send_request(olids_pkg::OP_SEARCH, 0, -1);
	endtask

	// Fill to capacity, drain to empty and mix, over and over
	task automatic test_fill_drain;
		int sent;
		sent = 0;
		while (sent < 1100) begin
			while (list_len < olids_pkg::CAPACITY) begin
				random_item(80, 10, 1'b0);
				sent++;
			end
			repeat ($urandom_range(1, 4)) begin
				random_item(80, 10, 1'b0);
				sent++;
			end
			while (list_len > 0) begin
				random_item(10, 80, 1'b0);
				sent++;
			end
			repeat ($urandom_range(1, 4)) begin
				random_item(10, 80, 1'b0);
				sent++;
			end
			repeat ($urandom_range(20, 60)) begin
				random_item(40, 35, 1'b0);
				sent++;
			end
		end
	endtask

	// Any operation code, any position
	task automatic test_random_noise;
		repeat (200) random_item(40, 30, 1'b1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_edge_values();
		test_fill_drain();
		test_random_noise();
		start <= 1'b0;

		// Drain outstanding results, then allow for one more full walk
		while (pending_results.size() != 0) @(posedge clk);
		repeat (olids_pkg::CAPACITY + 8) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
